@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds whenever ante holds.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that cons holds a fixed number of cycles after ante.
`define ASSERT_DELAY(label, clk, rst_n, ante, dly, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("assertion failed");

`endif

@@ design/bsc_pkg.sv @@
// ---------------------------------------------------------------------------
// bsc_pkg
// Widths, constants and register indexes of the barometric compensation.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package bsc_pkg;

  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int TEMP_W  = 20;
  localparam int PRES_W  = 32;
  localparam int CFG_AW  = 5;
  localparam int CFG_DW  = 32;
  localparam int LATENCY = 8;

  localparam logic [18:0] TEMP_BASE = 19'd2000;

  localparam logic [2:0] REG_SENS_REF   = 3'd0;
  localparam logic [2:0] REG_OFF_REF    = 3'd1;
  localparam logic [2:0] REG_SENS_TC    = 3'd2;
  localparam logic [2:0] REG_OFF_TC     = 3'd3;
  localparam logic [2:0] REG_TEMP_REF   = 3'd4;
  localparam logic [2:0] REG_TEMP_SLOPE = 3'd5;

  typedef logic [COEF_W-1:0] coef_t;

endpackage

@@ design/baro_sensor_compensation.sv @@
// ---------------------------------------------------------------------------
// baro_sensor_compensation
// Second-order compensation of raw pressure and temperature conversions.
//
//   channel | ports                                   | handshake
//   --------+-----------------------------------------+----------------------
//   input   | in_raw_pressure, in_raw_temperature     | start, busy
//   result  | out_temperature_cx100, out_pressure_q8  | out_strobe
//   config  | psel penable pwrite paddr pwdata prdata | pready
//
// Eight-stage pipeline; one transfer per cycle, busy stays low.
// A start transfer's valid bit runs through v_r[1] to v_r[7] and then out_strobe.
// The multiplier stages hold the coefficient products, the
// second-order square and the split pressure product.
// Reset clears the valid bits and the coefficients; payload is not reset.
// The receiver cannot stall, so the pipeline always advances.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module baro_sensor_compensation
  import bsc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [RAW_W-1:0]         in_raw_pressure,
  input  logic [RAW_W-1:0]         in_raw_temperature,
  output logic                     out_strobe,
  output logic signed [TEMP_W-1:0] out_temperature_cx100,
  output logic signed [PRES_W-1:0] out_pressure_q8,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_AW-1:0]        paddr,
  input  logic [CFG_DW-1:0]        pwdata,
  output logic [CFG_DW-1:0]        prdata,
  output logic                     pready
);

  coef_t sens_ref_r, off_ref_r, sens_tc_r, off_tc_r, temp_ref_r, temp_slope_r;
  logic  [2:0] cfg_idx;
  logic        cfg_wr;
  coef_t       cfg_rd;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign cfg_idx = paddr[CFG_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_ref_r   <= '0;
      off_ref_r    <= '0;
      sens_tc_r    <= '0;
      off_tc_r     <= '0;
      temp_ref_r   <= '0;
      temp_slope_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_SENS_REF:   sens_ref_r   <= pwdata[COEF_W-1:0];
        REG_OFF_REF:    off_ref_r    <= pwdata[COEF_W-1:0];
        REG_SENS_TC:    sens_tc_r    <= pwdata[COEF_W-1:0];
        REG_OFF_TC:     off_tc_r     <= pwdata[COEF_W-1:0];
        REG_TEMP_REF:   temp_ref_r   <= pwdata[COEF_W-1:0];
        REG_TEMP_SLOPE: temp_slope_r <= pwdata[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SENS_REF:   cfg_rd = sens_ref_r;
      REG_OFF_REF:    cfg_rd = off_ref_r;
      REG_SENS_TC:    cfg_rd = sens_tc_r;
      REG_OFF_TC:     cfg_rd = off_tc_r;
      REG_TEMP_REF:   cfg_rd = temp_ref_r;
      REG_TEMP_SLOPE: cfg_rd = temp_slope_r;
      default:        cfg_rd = '0;
    endcase
  end

  assign prdata = {{(CFG_DW-COEF_W){1'b0}}, cfg_rd};

  // valid bits
  logic [7:1] v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r        <= '0;
      out_strobe <= 1'b0;
    end else begin
      v_r        <= {v_r[6:1], start && !busy};
      out_strobe <= v_r[7];
    end
  end

  // stage 1: temperature difference
  logic [RAW_W-1:0]   d1_1_r;
  logic signed [24:0] dt_1_r;

  always_ff @(posedge clk) begin
    d1_1_r <= in_raw_pressure;
    dt_1_r <= $signed({1'b0, in_raw_temperature}) - $signed({1'b0, temp_ref_r, 8'b0});
  end

  // stage 2: coefficient products and dT squared
  logic signed [16:0] slope_s, off_tc_s, sens_tc_s;
  logic signed [40:0] pt_nxt, po_nxt, ps_nxt;
  logic signed [49:0] dsq_nxt;
  logic [RAW_W-1:0]   d1_2_r;
  logic signed [40:0] pt_2_r, po_2_r, ps_2_r;
  logic [47:0]        dsq_2_r;

  assign slope_s   = $signed({1'b0, temp_slope_r});
  assign off_tc_s  = $signed({1'b0, off_tc_r});
  assign sens_tc_s = $signed({1'b0, sens_tc_r});
  assign pt_nxt    = dt_1_r * slope_s;
  assign po_nxt    = dt_1_r * off_tc_s;
  assign ps_nxt    = dt_1_r * sens_tc_s;
  assign dsq_nxt   = dt_1_r * dt_1_r;

  always_ff @(posedge clk) begin
    d1_2_r  <= d1_1_r;
    pt_2_r  <= pt_nxt;
    po_2_r  <= po_nxt;
    ps_2_r  <= ps_nxt;
    dsq_2_r <= dsq_nxt[47:0];
  end

  // stage 3: first-order temperature, offset and sensitivity
  logic               low_nxt;
  logic [RAW_W-1:0]   d1_3_r;
  logic signed [18:0] temp_3_r;
  logic signed [34:0] off_3_r;
  logic signed [33:0] sens_3_r;
  logic signed [17:0] d_3_r;
  logic [16:0]        t2_3_r;
  logic               low_3_r;

  assign low_nxt = pt_2_r[40];

  always_ff @(posedge clk) begin
    d1_3_r   <= d1_2_r;
    temp_3_r <= $signed({pt_2_r[40], pt_2_r[40:23]}) + $signed(TEMP_BASE);
    off_3_r  <= $signed({3'b0, off_ref_r, 16'b0}) + $signed({po_2_r[40], po_2_r[40:7]});
    sens_3_r <= $signed({3'b0, sens_ref_r, 15'b0}) + $signed({ps_2_r[40], ps_2_r[40:8]});
    d_3_r    <= low_nxt ? pt_2_r[40:23] : 18'sd0;
    t2_3_r   <= low_nxt ? dsq_2_r[47:31] : 17'd0;
    low_3_r  <= low_nxt;
  end

  // stage 4: second-order temperature, square of the low-temperature delta
  logic signed [35:0] dd_nxt;
  logic [RAW_W-1:0]   d1_4_r;
  logic signed [TEMP_W-1:0] temp_4_r;
  logic signed [34:0] off_4_r;
  logic signed [33:0] sens_4_r;
  logic [34:0]        dd_4_r;
  logic               low_4_r;

  assign dd_nxt = d_3_r * d_3_r;

  always_ff @(posedge clk) begin
    d1_4_r   <= d1_3_r;
    temp_4_r <= $signed({temp_3_r[18], temp_3_r}) - $signed({3'b0, t2_3_r});
    off_4_r  <= off_3_r;
    sens_4_r <= sens_3_r;
    dd_4_r   <= dd_nxt[34:0];
    low_4_r  <= low_3_r;
  end

  // stage 5: apply second-order offset and sensitivity
  logic [36:0]        five_dd;
  logic [RAW_W-1:0]   d1_5_r;
  logic signed [TEMP_W-1:0] temp_5_r;
  logic signed [37:0] off_5_r;
  logic signed [36:0] sens_5_r;

  assign five_dd = {2'b0, dd_4_r} + {dd_4_r, 2'b0};

  always_ff @(posedge clk) begin
    d1_5_r   <= d1_4_r;
    temp_5_r <= temp_4_r;
    off_5_r  <= $signed({{3{off_4_r[34]}}, off_4_r}) - $signed({2'b0, five_dd[36:1]});
    sens_5_r <= $signed({{3{sens_4_r[33]}}, sens_4_r}) - $signed({2'b0, five_dd[36:2]});
  end

  // stage 6: split pressure product
  logic signed [24:0] d1_s;
  logic signed [19:0] sens_lo_s;
  logic signed [17:0] sens_hi_s;
  logic signed [44:0] pp_lo_nxt;
  logic signed [42:0] pp_hi_nxt;
  logic signed [44:0] pp_lo_6_r;
  logic signed [42:0] pp_hi_6_r;
  logic signed [37:0] off_6_r;
  logic signed [TEMP_W-1:0] temp_6_r;

  assign d1_s      = $signed({1'b0, d1_5_r});
  assign sens_lo_s = $signed({1'b0, sens_5_r[18:0]});
  assign sens_hi_s = sens_5_r[36:19];
  assign pp_lo_nxt = d1_s * sens_lo_s;
  assign pp_hi_nxt = d1_s * sens_hi_s;

  always_ff @(posedge clk) begin
    pp_lo_6_r <= pp_lo_nxt;
    pp_hi_6_r <= pp_hi_nxt;
    off_6_r   <= off_5_r;
    temp_6_r  <= temp_5_r;
  end

  // stage 7: pressure numerator
  logic [63:0] num_7_r;
  logic signed [TEMP_W-1:0] temp_7_r;

  always_ff @(posedge clk) begin
    num_7_r  <= {{2{pp_hi_6_r[42]}}, pp_hi_6_r, 19'b0}
              + {{19{pp_lo_6_r[44]}}, pp_lo_6_r}
              - {{5{off_6_r[37]}}, off_6_r, 21'b0};
    temp_7_r <= temp_6_r;
  end

  // stage 8: floor, saturate and drive the result
  logic [35:0]       p_full;
  logic              p_fits;
  logic [PRES_W-1:0] p_sat;

  assign p_full = num_7_r[63:28];
  assign p_fits = (p_full[35:31] == 5'b00000) || (p_full[35:31] == 5'b11111);

  always_comb begin
    if (p_fits) begin
      p_sat = p_full[31:0];
    end else if (p_full[35]) begin
      p_sat = {1'b1, {(PRES_W-1){1'b0}}};
    end else begin
      p_sat = {1'b0, {(PRES_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    out_temperature_cx100 <= temp_7_r;
    out_pressure_q8       <= $signed(p_sat);
  end

  `ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, 8, out_strobe)
  `ASSERT_IMPLY(a_no_orphan, clk, rst_n, out_strobe, $past(start, LATENCY))
  `ASSERT_IMPLY(a_warm_no_corr, clk, rst_n, v_r[4] && !low_4_r, dd_4_r == 35'd0)
  `ASSERT_IMPLY(a_warm_no_t2, clk, rst_n, v_r[3] && !low_3_r, t2_3_r == 17'd0)

endmodule
